>>> hdl/bvg_pkg.sv
// bvg_pkg: shared types, constants and the state-of-charge map of the battery gauge
// used by battery_voltage_gauge, bvg_cfg, bvg_ring and bvg_map; no dependencies
package bvg_pkg;

    // value every history entry reads as after reset
    localparam logic [15:0] RESET_MV = 16'd3300;

    // register reset values
    localparam logic [15:0] LOW_ALERT_RESET = 16'd3100;
    localparam logic [15:0] CHARGE_RESET    = 16'd3550;

    // register select, taken from paddr[2]
    localparam logic REG_LOW_ALERT = 1'b0;
    localparam logic REG_CHARGE    = 1'b1;

    // lifepo4 open-circuit-voltage breakpoints
    localparam int OCV_N = 7;
    localparam int SEG_N = OCV_N - 1;
    localparam int SEG_W = 3;

    localparam logic [15:0] OCV_MV [OCV_N] = '{
        16'd3100, 16'd3200, 16'd3300, 16'd3350, 16'd3400, 16'd3450, 16'd3650
    };
    localparam logic [6:0] OCV_PCT [OCV_N] = '{
        7'd0, 7'd0, 7'd20, 7'd50, 7'd80, 7'd100, 7'd100
    };

    // each segment's slope is k/5 percent per mV (20/100, 30/50, 30/50, 20/50),
    // flat segments have k of zero
    localparam logic [1:0] SEG_K [SEG_N] = '{2'd0, 2'd1, 2'd3, 2'd3, 2'd2, 2'd0};

    // divide by 5 as a multiply by 205 / 1024, exact for products below 512
    localparam logic [7:0] DIV5_RECIP = 8'd205;
    localparam int         DIV5_SHIFT = 10;

    // threshold registers as seen by the datapath
    typedef struct packed {
        logic [15:0] low_alert_mv;
        logic [15:0] charge_detect_mv;
    } cfg_t;

    // piecewise linear state of charge from a filtered voltage
    function automatic logic [6:0] soc_of(input logic [15:0] mv);
        logic             found;
        logic [SEG_W-1:0] seg;
        logic [7:0]       dmv;
        logic [8:0]       num;
        logic [16:0]      prod;
        logic [6:0]       res;
        found = 1'b0;
        seg   = '0;
        for (int k = 0; k < SEG_N; k++) begin
            // lower segment wins at a shared breakpoint
            if (!found && mv <= OCV_MV[k + 1]) begin
                seg   = SEG_W'(k);
                found = 1'b1;
            end
        end
        dmv  = 8'(mv - OCV_MV[seg]);
        num  = 9'(dmv * SEG_K[seg]);
        prod = 17'(num) * 17'(DIV5_RECIP);
        res  = OCV_PCT[seg] + 7'(prod >> DIV5_SHIFT);
        if (mv <= OCV_MV[0]) begin
            res = 7'd0;
        end else if (mv >= OCV_MV[OCV_N - 1]) begin
            res = 7'd100;
        end
        return res;
    endfunction

endpackage

>>> hdl/battery_voltage_gauge.sv
// battery_voltage_gauge: moving average battery gauge with lifepo4 state of charge
// stages: ring stage one, running sum, mean product, output register
// throughput: one item per cycle if not stalled, set by the one history read and write
// reset: synchronous active low; history reads as 3300 mV, thresholds 3100 / 3550 mV
// depends on bvg_pkg, bvg_cfg, bvg_ring, bvg_div, bvg_map
module battery_voltage_gauge #(
    parameter int WINDOW = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample_mv
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] filtered_mv, [22:16] soc_percent,
                                   // [23] low_alert, [24] charging, [31:25] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bvg_pkg::*;

    localparam int SUM_W = 16 + $clog2(WINDOW);

    logic             en;
    logic             in_accept;
    cfg_t             cfg;
    logic             sum_valid;
    logic [SUM_W-1:0] sum;
    logic             mean_valid;
    logic [15:0]      mean_mv;
    logic [15:0]      filtered_mv;
    logic [6:0]       soc_percent;
    logic             low_alert;
    logic             charging;

    // whole pipeline advances unless the output register is full and stalled
    assign en        = ~m_tvalid | m_tready;
    assign s_tready  = en;
    assign in_accept = s_tvalid & en;

    bvg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bvg_ring #(.WINDOW(WINDOW)) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_accept (in_accept),
        .sample    (s_tdata),
        .sum_valid (sum_valid),
        .sum_out   (sum)
    );

    bvg_div #(.WINDOW(WINDOW)) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (sum_valid),
        .sum_in     (sum),
        .mean_valid (mean_valid),
        .mean_mv    (mean_mv)
    );

    bvg_map u_map (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (mean_valid),
        .mean_mv     (mean_mv),
        .cfg         (cfg),
        .out_valid   (m_tvalid),
        .filtered_mv (filtered_mv),
        .soc_percent (soc_percent),
        .low_alert   (low_alert),
        .charging    (charging)
    );

    // result packing
    assign m_tdata = {7'd0, charging, low_alert, soc_percent, filtered_mv};

endmodule

>>> hdl/bvg_cfg.sv
// bvg_cfg: apb register block holding the low alert and charge detect thresholds
// depends on bvg_pkg
module bvg_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output bvg_pkg::cfg_t cfg
);
    import bvg_pkg::*;

    logic [15:0] low_alert_reg;
    logic [15:0] charge_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    // register writes, byte offset bits ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_alert_reg <= LOW_ALERT_RESET;
            charge_reg    <= CHARGE_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_LOW_ALERT: low_alert_reg <= pwdata[15:0];
                REG_CHARGE:    charge_reg    <= pwdata[15:0];
                default:       ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_LOW_ALERT: prdata = {16'd0, low_alert_reg};
            REG_CHARGE:    prdata = {16'd0, charge_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.low_alert_mv     = low_alert_reg;
    assign cfg.charge_detect_mv = charge_reg;

endmodule

>>> hdl/bvg_ring.sv
// bvg_ring: sample history ring in a synchronous memory plus the running window sum
// depends on bvg_pkg
module bvg_ring #(
    parameter int WINDOW = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_accept,
    input  logic [15:0]                     sample,
    output logic                            sum_valid,
    output logic [16+$clog2(WINDOW)-1:0]    sum_out
);
    import bvg_pkg::*;

    localparam int POS_W = $clog2(WINDOW);
    localparam int SUM_W = 16 + $clog2(WINDOW);
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(WINDOW * int'(RESET_MV));
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(WINDOW - 1);

    logic [15:0]       mem [WINDOW];
    logic [WINDOW-1:0] vld_reg;
    logic [POS_W-1:0]  rd_ptr_reg;
    logic [POS_W-1:0]  rd_ptr_next;
    logic              s1_valid_reg;
    logic [POS_W-1:0]  s1_pos_reg;
    logic [15:0]       s1_sample_reg;
    logic [15:0]       rd_data_reg;
    logic              rd_hit_reg;
    logic [15:0]       old_mv;
    logic              wr_en;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              sum_valid_reg;

    assign rd_ptr_next = (rd_ptr_reg == POS_LAST) ? '0 : rd_ptr_reg + POS_W'(1);
    assign wr_en       = en & s1_valid_reg;

    // entries never written read as the reset voltage
    assign old_mv   = rd_hit_reg ? rd_data_reg : RESET_MV;
    assign sum_next = sum_reg - SUM_W'(old_mv) + SUM_W'(s1_sample_reg);

    // history memory: read slot on accept, write back from the stage one registers
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s1_pos_reg] <= s1_sample_reg;
        end
        if (in_accept) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // stage one payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_pos_reg    <= rd_ptr_reg;
            s1_sample_reg <= sample;
            rd_hit_reg    <= vld_reg[rd_ptr_reg];
        end
    end

    // pointer, written flags, running sum and stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg    <= '0;
            vld_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            sum_reg       <= SUM_RESET;
        end else begin
            if (in_accept) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (en) begin
                s1_valid_reg  <= in_accept;
                sum_valid_reg <= s1_valid_reg;
            end
            if (wr_en) begin
                vld_reg[s1_pos_reg] <= 1'b1;
                sum_reg             <= sum_next;
            end
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum_out   = sum_reg;

endmodule

>>> hdl/bvg_div.sv
// bvg_div: window mean by multiplication with a fixed reciprocal of the window length
// no package dependencies
module bvg_div #(
    parameter int WINDOW = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [16+$clog2(WINDOW)-1:0]    sum_in,
    output logic                            mean_valid,
    output logic [15:0]                     mean_mv
);
    localparam int SUM_W   = 16 + $clog2(WINDOW);
    localparam int SHIFT   = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // ceil(2^SHIFT / WINDOW) gives an exact floor quotient for any SUM_W-bit sum
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;
    logic              valid_reg;

    assign prod_next = {{RECIP_W{1'b0}}, sum_in} * {{SUM_W{1'b0}}, RECIP};

    // product register
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    assign mean_valid = valid_reg;
    assign mean_mv    = prod_reg[SHIFT+15:SHIFT];

endmodule

>>> hdl/bvg_map.sv
// bvg_map: state-of-charge interpolation, threshold flags and the output register
// depends on bvg_pkg
module bvg_map (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [15:0]   mean_mv,
    input  bvg_pkg::cfg_t cfg,
    output logic          out_valid,
    output logic [15:0]   filtered_mv,
    output logic [6:0]    soc_percent,
    output logic          low_alert,
    output logic          charging
);
    import bvg_pkg::*;

    logic        valid_reg;
    logic [15:0] filtered_reg;
    logic [6:0]  soc_reg;
    logic        low_reg;
    logic        chg_reg;

    // result payload
    always_ff @(posedge aclk) begin
        if (en) begin
            filtered_reg <= mean_mv;
            soc_reg      <= soc_of(mean_mv);
            low_reg      <= (mean_mv < cfg.low_alert_mv);
            chg_reg      <= (mean_mv > cfg.charge_detect_mv);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid   = valid_reg;
    assign filtered_mv = filtered_reg;
    assign soc_percent = soc_reg;
    assign low_alert   = low_reg;
    assign charging    = chg_reg;

endmodule
